// ===== hw/rtl/dedup_then_sort_records_desc_macros.svh =====
// Assertion macros shared by the record dedup and sort block.
`ifndef DEDUP_THEN_SORT_RECORDS_DESC_MACROS_SVH
`define DEDUP_THEN_SORT_RECORDS_DESC_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DTSR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DTSR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/dtsr_pkg.sv =====
// Types, constants and name comparison for the record dedup and sort block.
`timescale 1ns / 1ps
`default_nettype none
package dtsr_pkg;

   localparam int DEF_MAX_RECORDS = 16;
   localparam int NAME_BYTES      = 20;

   typedef struct packed {
      logic [30:0] id_number;
      logic [63:0] first_name_w0;
      logic [63:0] first_name_w1;
      logic [31:0] first_name_w2;
      logic [63:0] surname_w0;
      logic [63:0] surname_w1;
      logic [31:0] surname_w2;
      logic [15:0] sort_key;
      logic        final_record;
   } req_type;

   typedef struct packed {
      logic [30:0] out_id_number;
      logic [63:0] out_first_name_w0;
      logic [63:0] out_first_name_w1;
      logic [31:0] out_first_name_w2;
      logic [63:0] out_surname_w0;
      logic [63:0] out_surname_w1;
      logic [31:0] out_surname_w2;
      logic [15:0] out_sort_key;
      logic        overflow_seen;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [30:0]  id;
      logic [159:0] fname;
      logic [159:0] sname;
      logic [15:0]  key;
   } rec_type;

   typedef struct packed {
      logic wr_en;
      logic wr_pivot;
      logic load_new;
      logic load_pivot;
      logic load_out;
      logic out_last;
      logic out_ovf;
   } cmd_type;

   typedef struct packed {
      logic match;
      logic key_gt;
      logic final_rec;
      logic out_free;
   } sts_type;

   // Compare two zero-terminated names; stored name a, new name b.
   function automatic logic name_equal(logic [8*NAME_BYTES-1:0] a,
                                       logic [8*NAME_BYTES-1:0] b);
      logic seen_zero;
      logic same;
      seen_zero = 1'b0;
      same      = 1'b1;
      for (int k = 0; k < NAME_BYTES; k++) begin
         if (!seen_zero && (a[8*k +: 8] != b[8*k +: 8])) begin
            same = 1'b0;
         end
         if (a[8*k +: 8] == 8'h00) begin
            seen_zero = 1'b1;
         end
      end
      return same;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dtsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dtsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/dtsr_dpath.sv =====
// Datapath: record store, new record and pivot registers, result register.
`timescale 1ns / 1ps
`default_nettype none
module dtsr_dpath import dtsr_pkg::*; #(
   parameter int MAX_RECORDS = DEF_MAX_RECORDS,
   parameter int IDX_W       = $clog2(MAX_RECORDS)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire req_type          req_data,
   input  wire logic             rsp_stall,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  wire cmd_type          cmd,
   input  wire logic [IDX_W-1:0] rd_addr,
   input  wire logic [IDX_W-1:0] wr_addr,
   output sts_type               sts
);

   rec_type new_ff;
   logic    final_ff;
   rec_type pivot_ff;
   rec_type rd_rec;
   rec_type wr_rec;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   assign wr_rec = cmd.wr_pivot ? pivot_ff : new_ff;

   dtsr_ram #(
      .WIDTH ($bits(rec_type)),
      .DEPTH (MAX_RECORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_addr (rd_addr),
      .rd_data (rd_rec)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_new) begin
         new_ff.id    <= req_data.id_number;
         new_ff.fname <= {req_data.first_name_w2, req_data.first_name_w1,
                          req_data.first_name_w0};
         new_ff.sname <= {req_data.surname_w2, req_data.surname_w1,
                          req_data.surname_w0};
         new_ff.key   <= req_data.sort_key;
         final_ff     <= req_data.final_record;
      end
      if (cmd.load_pivot) begin
         pivot_ff <= rd_rec;
      end
      if (cmd.load_out) begin
         rsp_ff.out_id_number     <= rd_rec.id;
         rsp_ff.out_first_name_w0 <= rd_rec.fname[63:0];
         rsp_ff.out_first_name_w1 <= rd_rec.fname[127:64];
         rsp_ff.out_first_name_w2 <= rd_rec.fname[159:128];
         rsp_ff.out_surname_w0    <= rd_rec.sname[63:0];
         rsp_ff.out_surname_w1    <= rd_rec.sname[127:64];
         rsp_ff.out_surname_w2    <= rd_rec.sname[159:128];
         rsp_ff.out_sort_key      <= rd_rec.key;
         rsp_ff.overflow_seen     <= cmd.out_ovf;
         rsp_ff.last_of_run       <= cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.match     = name_equal(rd_rec.fname, new_ff.fname) &&
                          name_equal(rd_rec.sname, new_ff.sname);
   assign sts.key_gt    = rd_rec.key > pivot_ff.key;
   assign sts.final_rec = final_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/dtsr_ctrl.sv =====
// Controller: load, dedup scan, exchange sort and emission sequencing.
`timescale 1ns / 1ps
`default_nettype none
`include "dedup_then_sort_records_desc_macros.svh"
module dtsr_ctrl import dtsr_pkg::*; #(
   parameter int MAX_RECORDS = DEF_MAX_RECORDS,
   parameter int IDX_W       = $clog2(MAX_RECORDS),
   parameter int CNT_W       = $clog2(MAX_RECORDS + 1)
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire sts_type     sts,
   output cmd_type          cmd,
   output logic [IDX_W-1:0] rd_addr,
   output logic [IDX_W-1:0] wr_addr
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_SORT_LOAD,
      ST_SORT_PIV,
      ST_SORT_SCAN,
      ST_SORT_PUT,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] ia_ff, ia_in;
   logic [CNT_W-1:0] jb_ff, jb_in;
   logic [IDX_W-1:0] cmp_ff, cmp_in;
   state_type        after_load;

   assign after_load = sts.final_rec ? ST_SORT_LOAD : ST_IDLE;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      ia_in    = ia_ff;
      jb_in    = jb_ff;
      cmp_in   = cmp_ff;
      cmd      = '0;
      rd_addr  = '0;
      wr_addr  = cmp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_new = 1'b1;
               cmp_in       = '0;
               jb_in        = CNT_W'(1);
               state_in     = (count_ff == '0) ? ST_INSERT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.match) begin
               cmd.wr_en = 1'b1;
               ia_in     = '0;
               state_in  = after_load;
            end else if (jb_ff < count_ff) begin
               rd_addr = jb_ff[IDX_W-1:0];
               cmp_in  = jb_ff[IDX_W-1:0];
               jb_in   = jb_ff + CNT_W'(1);
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            if (count_ff < CNT_W'(MAX_RECORDS)) begin
               cmd.wr_en = 1'b1;
               wr_addr   = count_ff[IDX_W-1:0];
               count_in  = count_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
            ia_in    = '0;
            state_in = after_load;
         end
         ST_SORT_LOAD: begin
            if (count_ff < CNT_W'(2)) begin
               jb_in    = '0;
               state_in = ST_EMIT_RD;
            end else begin
               rd_addr  = ia_ff;
               state_in = ST_SORT_PIV;
            end
         end
         ST_SORT_PIV: begin
            cmd.load_pivot = 1'b1;
            rd_addr        = ia_ff + IDX_W'(1);
            cmp_in         = ia_ff + IDX_W'(1);
            jb_in          = CNT_W'(ia_ff) + CNT_W'(2);
            state_in       = ST_SORT_SCAN;
         end
         ST_SORT_SCAN: begin
            if (sts.key_gt) begin
               cmd.wr_en      = 1'b1;
               cmd.wr_pivot   = 1'b1;
               cmd.load_pivot = 1'b1;
            end
            if (jb_ff < count_ff) begin
               rd_addr = jb_ff[IDX_W-1:0];
               cmp_in  = jb_ff[IDX_W-1:0];
               jb_in   = jb_ff + CNT_W'(1);
            end else begin
               state_in = ST_SORT_PUT;
            end
         end
         ST_SORT_PUT: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_pivot = 1'b1;
            wr_addr      = ia_ff;
            if (CNT_W'(ia_ff) + CNT_W'(2) < count_ff) begin
               ia_in    = ia_ff + IDX_W'(1);
               state_in = ST_SORT_LOAD;
            end else begin
               jb_in    = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            rd_addr  = jb_ff[IDX_W-1:0];
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            rd_addr = jb_ff[IDX_W-1:0];
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_ovf  = ovf_ff;
               cmd.out_last = (jb_ff + CNT_W'(1)) == count_ff;
               if (cmd.out_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  jb_in    = jb_ff + CNT_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         ia_ff    <= '0;
         jb_ff    <= '0;
         cmp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         ia_ff    <= ia_in;
         jb_ff    <= jb_in;
         cmp_ff   <= cmp_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   `DTSR_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_RECORDS), "record count beyond table size")
   `DTSR_ASSERT_IMP(a_write_in_range, clock, reset, cmd.wr_en, CNT_W'(wr_addr) <= count_ff, "store write beyond filled slots")
   `DTSR_ASSERT_NXT(a_run_end_clears, clock, reset, cmd.load_out && cmd.out_last, count_ff == '0 && !ovf_ff && state_ff == ST_IDLE, "set not cleared after last result")
   `DTSR_ASSERT_IMP(a_out_only_free, clock, reset, cmd.load_out, sts.out_free && state_ff == ST_EMIT_LD, "result loaded while register busy")

endmodule
`default_nettype wire

// ===== hw/rtl/dedup_then_sort_records_desc.sv =====
// Record loader with name deduplication and descending exchange sort by count.
//
// Usage:
//   req_ channel: one record per request (id, two 20-byte names, count and a
//   final flag). Each request is merged into the table: a record whose first
//   name and surname match a stored one replaces it in its slot, otherwise it
//   is appended, or dropped with the overflow mark set when the table is full.
//   A final request then sorts the table by count, largest first, and the
//   rsp_ channel returns every stored record in slot order, last_of_run high on
//   the final one and overflow_seen high if any record of the set was dropped.
//   A load scans the stored records at one store read per cycle through the
//   single read port of the record memory. The sort places the largest
//   remaining record in each slot in turn, and emission reads each result
//   from the store before loading it into the output register.
//   req_stall is high whenever a request is in progress; a finished result
//   waits in the output register while rsp_stall is high and the sequence
//   pauses. Reset empties the table and clears the overflow mark; the record
//   memory itself is not cleared, as only filled slots are ever used.
`timescale 1ns / 1ps
`default_nettype none
module dedup_then_sort_records_desc import dtsr_pkg::*; #(
   parameter int MAX_RECORDS = DEF_MAX_RECORDS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(MAX_RECORDS);
   localparam int CNT_W = $clog2(MAX_RECORDS + 1);

   cmd_type          cmd;
   sts_type          sts;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;

   dtsr_ctrl #(
      .MAX_RECORDS (MAX_RECORDS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr)
   );

   dtsr_dpath #(
      .MAX_RECORDS (MAX_RECORDS),
      .IDX_W       (IDX_W)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .sts       (sts)
   );

endmodule
`default_nettype wire
